FILE: rtl/core/e2q_pkg.sv
// e2q_pkg: widths, constants, the arctangent table and the trig pair type
// shared by the euler_to_quaternion top level and its cordic pipeline
// no dependencies
`default_nettype none

package e2q_pkg;

    // field widths
    localparam int ANGLE_W          = 16;
    localparam int OUT_W            = 16;

    // cordic step count: default and the most the table supports
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_ENTRIES     = 24;
    localparam int ATAN_IDX_W       = $clog2(ATAN_ENTRIES);
    localparam int ATAN_W           = 32;

    // internal datapath widths
    localparam int XY_W             = 34;              // cordic x/y, Q2.30 plus headroom
    localparam int Z_W              = 33;              // residual angle, Q2.30
    localparam int Z_SHIFT          = 16;              // Q13 angle to Q30 half angle
    localparam int TRIG_W           = 22;              // sine/cosine in Q20
    localparam int TRIG_SHIFT       = 10;              // Q30 to Q20
    localparam int PAIR_W           = 2 * TRIG_W;      // Q40 products
    localparam int TRIP_W           = PAIR_W + TRIG_W; // Q60 products
    localparam int SUM_W            = TRIP_W + 1;
    localparam int OUT_SHIFT        = 46;              // Q60 to Q14

    // numeric constants
    localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT = 16'sd25736;
    localparam logic signed [XY_W-1:0]    GAIN_Q30    = 34'sd652032874;
    localparam logic signed [OUT_W-1:0]   ONE_Q14     = 16'sd16384;

    // atan(2^-i) in Q30, rounded down
    localparam logic [ATAN_W-1:0] ATAN_Q30 [ATAN_ENTRIES] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
        32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
        32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
        32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
        32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
    };

    // sine and cosine of one half angle
    typedef logic signed [TRIG_W-1:0] t_trig_val;

    typedef struct packed {
        t_trig_val sin_v;
        t_trig_val cos_v;
    } t_trig;

endpackage

`default_nettype wire

FILE: rtl/core/e2q_cordic.sv
// e2q_cordic: clamp, halve and rotate one angle through a pipelined cordic,
// one register stage per step, then round sine and cosine to Q20
// depends on e2q_pkg
`default_nettype none

module e2q_cordic #(
    parameter int STEPS = e2q_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [e2q_pkg::ANGLE_W-1:0]  i_angle,
    output e2q_pkg::t_trig                      o_trig
);
    import e2q_pkg::*;

    localparam logic signed [XY_W-1:0] RND_TRIG = XY_W'(1) <<< (TRIG_SHIFT - 1);

    logic signed [ANGLE_W-1:0] n_clamp;
    logic signed [Z_W-1:0]     n_z0;
    logic signed [XY_W-1:0]    n_cos_full;
    logic signed [XY_W-1:0]    n_sin_full;

    logic signed [XY_W-1:0]    r_x [STEPS+1];
    logic signed [XY_W-1:0]    r_y [STEPS+1];
    logic signed [Z_W-1:0]     r_z [STEPS+1];
    t_trig                     r_trig;

    // clamp to +-pi, half angle in Q30
    always_comb begin
        if (i_angle > ANGLE_LIMIT) begin
            n_clamp = ANGLE_LIMIT;
        end else if (i_angle < -ANGLE_LIMIT) begin
            n_clamp = -ANGLE_LIMIT;
        end else begin
            n_clamp = i_angle;
        end
        n_z0 = signed'({{(Z_W - ANGLE_W - Z_SHIFT){n_clamp[ANGLE_W-1]}},
                        n_clamp, {Z_SHIFT{1'b0}}});
    end

    // entry stage and one stage per rotation step
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= GAIN_Q30;
            r_y[0] <= '0;
            r_z[0] <= n_z0;
            for (int i = 0; i < STEPS; i++) begin
                if (!r_z[i][Z_W-1]) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - signed'({{(Z_W - ATAN_W){1'b0}},
                                                  ATAN_Q30[i[ATAN_IDX_W-1:0]]});
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + signed'({{(Z_W - ATAN_W){1'b0}},
                                                  ATAN_Q30[i[ATAN_IDX_W-1:0]]});
                end
            end
        end
    end

    // round half up to Q20
    always_comb begin
        n_cos_full = (r_x[STEPS] + RND_TRIG) >>> TRIG_SHIFT;
        n_sin_full = (r_y[STEPS] + RND_TRIG) >>> TRIG_SHIFT;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_trig.cos_v <= n_cos_full[TRIG_W-1:0];
            r_trig.sin_v <= n_sin_full[TRIG_W-1:0];
        end
    end

    assign o_trig = r_trig;

endmodule

`default_nettype wire

FILE: rtl/core/euler_to_quaternion.sv
// euler_to_quaternion: Z-Y-X euler angles to unit attitude quaternion in Q1.14
// three cordic lanes, a two-level product tree, round/saturate, output skid
// depends on e2q_pkg and e2q_cordic
//
//   channel | direction | handshake           | word
//   --------+-----------+---------------------+----------------------------------
//   angles  | in        | i_valid / o_stall   | i_yaw_angle i_pitch_angle i_roll_angle
//   quat    | out       | o_valid / i_stall   | o_w_part o_x_part o_y_part o_z_part
//
// stages, in order (steps capped at 24): one clamp stage, one stage per
// cordic step, rounding, pair products, triple products, sum/saturate,
// then the output register. one word per cycle is accepted while o_stall is low.
// reset is synchronous and clears the valid bits and the skid; payload is
// not reset. o_stall rises only when the output is held and the skid is full.
`default_nettype none

module euler_to_quaternion #(
    parameter int CORDIC_STEPS = e2q_pkg::CORDIC_STEPS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [e2q_pkg::ANGLE_W-1:0] i_yaw_angle,
    input  logic signed [e2q_pkg::ANGLE_W-1:0] i_pitch_angle,
    input  logic signed [e2q_pkg::ANGLE_W-1:0] i_roll_angle,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [e2q_pkg::OUT_W-1:0]   o_w_part,
    output logic signed [e2q_pkg::OUT_W-1:0]   o_x_part,
    output logic signed [e2q_pkg::OUT_W-1:0]   o_y_part,
    output logic signed [e2q_pkg::OUT_W-1:0]   o_z_part
);
    import e2q_pkg::*;

    localparam int STEPS = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
    localparam int NS    = STEPS + 5;
    localparam logic signed [SUM_W-1:0] RND_Q14 = SUM_W'(1) <<< (OUT_SHIFT - 1);

    typedef struct packed {
        logic signed [OUT_W-1:0] w;
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
        logic signed [OUT_W-1:0] z;
    } t_quat;

    logic                       en;
    logic [NS-1:0]              r_valid;
    t_trig                      trig_y, trig_p, trig_r;
    t_trig                      r_trig_y_d;
    logic signed [PAIR_W-1:0]   r_cc, r_ss, r_cs, r_sc;
    logic signed [TRIP_W-1:0]   r_w1, r_w2, r_x1, r_x2, r_y1, r_y2, r_z1, r_z2;
    t_quat                      n_quat, r_quat;
    t_quat                      r_out, r_skid;
    logic                       r_out_v, r_skid_v;

    // round Q60 sum to Q14 and saturate to +-1
    function automatic logic signed [OUT_W-1:0] to_q14(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] v;
        v = (s + RND_Q14) >>> OUT_SHIFT;
        if (v > ONE_Q14) begin
            v = SUM_W'(ONE_Q14);
        end else if (v < -ONE_Q14) begin
            v = -SUM_W'(ONE_Q14);
        end
        return v[OUT_W-1:0];
    endfunction

    // the pipeline moves whenever the skid has room
    assign en      = !r_skid_v;
    assign o_stall = r_skid_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (en) begin
            r_valid <= {r_valid[NS-2:0], i_valid};
        end
    end

    // half-angle sine and cosine lanes
    e2q_cordic #(.STEPS(STEPS)) u_cordic_yaw (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (i_yaw_angle),
        .o_trig  (trig_y)
    );

    e2q_cordic #(.STEPS(STEPS)) u_cordic_pitch (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (i_pitch_angle),
        .o_trig  (trig_p)
    );

    e2q_cordic #(.STEPS(STEPS)) u_cordic_roll (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (i_roll_angle),
        .o_trig  (trig_r)
    );

    // roll x pitch pair products, yaw delayed alongside
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cc       <= trig_r.cos_v * trig_p.cos_v;
            r_ss       <= trig_r.sin_v * trig_p.sin_v;
            r_cs       <= trig_r.cos_v * trig_p.sin_v;
            r_sc       <= trig_r.sin_v * trig_p.cos_v;
            r_trig_y_d <= trig_y;
        end
    end

    // triple products with yaw
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_w1 <= r_cc * r_trig_y_d.cos_v;
            r_w2 <= r_ss * r_trig_y_d.sin_v;
            r_x1 <= r_sc * r_trig_y_d.cos_v;
            r_x2 <= r_cs * r_trig_y_d.sin_v;
            r_y1 <= r_cs * r_trig_y_d.cos_v;
            r_y2 <= r_sc * r_trig_y_d.sin_v;
            r_z1 <= r_cc * r_trig_y_d.sin_v;
            r_z2 <= r_ss * r_trig_y_d.cos_v;
        end
    end

    // component sums, rounding and saturation
    always_comb begin
        n_quat.w = to_q14(SUM_W'(r_w1) + SUM_W'(r_w2));
        n_quat.x = to_q14(SUM_W'(r_x1) - SUM_W'(r_x2));
        n_quat.y = to_q14(SUM_W'(r_y1) + SUM_W'(r_y2));
        n_quat.z = to_q14(SUM_W'(r_z1) - SUM_W'(r_z2));
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_quat <= n_quat;
        end
    end

    // output register with one-word skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || !i_stall) begin
            if (r_skid_v) begin
                r_out    <= r_skid;
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else if (r_valid[NS-1]) begin
                r_out    <= r_quat;
                r_out_v  <= 1'b1;
            end else begin
                r_out_v  <= 1'b0;
            end
        end else if (r_valid[NS-1] && en) begin
            r_skid   <= r_quat;
            r_skid_v <= 1'b1;
        end
    end

    assign o_valid  = r_out_v;
    assign o_w_part = r_out.w;
    assign o_x_part = r_out.x;
    assign o_y_part = r_out.y;
    assign o_z_part = r_out.z;

    // input is held off only while a word waits in the output register
    a_stall_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("skid holds a word while the output register is empty");

    // a held output plus a fresh word from the pipeline fills the skid
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall && !o_stall && r_valid[NS-1]) |=> o_stall)
        else $error("word from the pipeline was not caught by the skid");

    // the skid empties as soon as the output is taken
    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_stall && !i_stall) |=> !o_stall)
        else $error("skid did not drain after the output was taken");

    // components stay on the unit range
    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_w_part <= ONE_Q14) && (o_w_part >= -ONE_Q14)
                 && (o_x_part <= ONE_Q14) && (o_x_part >= -ONE_Q14)
                 && (o_y_part <= ONE_Q14) && (o_y_part >= -ONE_Q14)
                 && (o_z_part <= ONE_Q14) && (o_z_part >= -ONE_Q14))
        else $error("quaternion component outside +-1");

endmodule

`default_nettype wire
